FILE: rtl/core/ptd_pkg.sv
// shared types and constants for the priority task dispatcher
// no dependencies; used by ptd_front, ptd_back, the top level and the testbench
package ptd_pkg;

	localparam int MAX_TASKS_DEF  = 16;
	localparam int NAME_CHARS_DEF = 8;
	localparam int KEY_W          = 64;
	localparam int PRIO_W         = 4;
	localparam int BURST_W        = 10;
	localparam int CNT_W          = 16;
	localparam int CMD_DEPTH      = 2;
	localparam int RES_DEPTH      = 2;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic {
		OP_ADD      = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	typedef struct packed {
		logic               func;
		logic [KEY_W-1:0]   task_key;
		logic [PRIO_W-1:0]  task_priority;
		logic [BURST_W-1:0] task_burst;
	} req_t;

	typedef struct packed {
		logic               accepted;
		logic               found;
		logic [KEY_W-1:0]   out_key;
		logic [PRIO_W-1:0]  out_priority;
		logic [BURST_W-1:0] out_burst;
		logic [CNT_W-1:0]   elapsed_total;
		logic [CNT_W-1:0]   dispatch_total;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] burst;
	} entry_t;

	typedef struct packed {
		op_t    op;
		entry_t entry;
	} cmd_t;

	// handshake between the command queue and the back end
	typedef struct packed {
		logic pop;
	} qctl_t;

endpackage

FILE: rtl/core/ptd_ram.sv
// generic single write port ram with registered read
// no dependencies
module ptd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/ptd_fifo.sv
// small register fifo with full and empty flags
// no dependencies
module ptd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/ptd_front.sv
// front end: trims the key to its name length, decodes the operation and queues the command
// depends on ptd_pkg and ptd_fifo
module ptd_front #(
	parameter int NAME_CHARS = ptd_pkg::NAME_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptd_pkg::req_t  request,
	output logic           full,
	input  ptd_pkg::qctl_t cmd_ctl_in,
	output ptd_pkg::cmd_t  cmd,
	output logic           cmd_empty
);

	// bytes past the name length are cleared
	localparam logic [ptd_pkg::KEY_W-1:0] KEY_MASK =
		{ptd_pkg::KEY_W{1'b1}} << (8 * (8 - NAME_CHARS));

	ptd_pkg::cmd_t cmd_new;
	logic [$bits(ptd_pkg::cmd_t)-1:0] cmd_bits;

	always_comb begin
		cmd_new             = '0;
		cmd_new.op          = request.func ? ptd_pkg::OP_DISPATCH : ptd_pkg::OP_ADD;
		cmd_new.entry.key   = request.task_key & KEY_MASK;
		cmd_new.entry.prio  = request.task_priority;
		cmd_new.entry.burst = request.task_burst;
	end

	ptd_fifo #(
		.WIDTH ($bits(ptd_pkg::cmd_t)),
		.DEPTH (ptd_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_new),
		.full   (full),
		.pop    (cmd_ctl_in.pop),
		.rdata  (cmd_bits),
		.empty  (cmd_empty)
	);

	assign cmd = ptd_pkg::cmd_t'(cmd_bits);

endmodule

FILE: rtl/core/ptd_back.sv
// back end: task table, sequential priority scan, counters and result queue
// depends on ptd_pkg, ptd_ram and ptd_fifo
module ptd_back #(
	parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ptd_pkg::cmd_t  cmd,
	input  logic           cmd_empty,
	output ptd_pkg::qctl_t cmd_ctl,
	input  logic           pop,
	output logic           empty,
	output ptd_pkg::rsp_t  response
);

	localparam int IW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ADD  = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_LAST = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t                          state_q;
	ptd_pkg::cmd_t                   cmd_q;
	logic [IW-1:0]                   idx_q;
	logic [MAX_TASKS-1:0]            valid_q;
	logic [CW-1:0]                   count_q;
	logic [ptd_pkg::CNT_W-1:0]       elapsed_q;
	logic [ptd_pkg::CNT_W-1:0]       dispatch_q;
	logic                            have_best_q;
	logic [IW-1:0]                   best_idx_q;
	ptd_pkg::entry_t                 best_q;
	logic                            rd_act_s1;
	logic                            rd_vld_s1;
	logic [IW-1:0]                   rd_idx_s1;
	logic [$bits(ptd_pkg::entry_t)-1:0] rd_bits;
	ptd_pkg::entry_t                 rd_entry;
	logic                            better;
	logic                            res_full;
	logic                            res_push;
	ptd_pkg::rsp_t                   res_data;
	logic                            cmd_take;
	logic                            table_full;
	logic                            table_empty;
	logic                            slot_free;
	logic                            ram_we;
	logic [ptd_pkg::CNT_W:0]         elapsed_sum;
	logic [ptd_pkg::CNT_W-1:0]       elapsed_nxt;
	logic [ptd_pkg::CNT_W-1:0]       dispatch_nxt;
	logic [$bits(ptd_pkg::rsp_t)-1:0] res_bits;

	assign table_full  = (count_q == CW'(MAX_TASKS));
	assign table_empty = (count_q == '0);
	assign slot_free   = !valid_q[idx_q];
	assign cmd_take    = (state_q == ST_IDLE) && !cmd_empty && !res_full;
	assign cmd_ctl.pop   = cmd_take;
	assign ram_we      = (state_q == ST_ADD) && slot_free;
	assign rd_entry    = ptd_pkg::entry_t'(rd_bits);

	// higher priority wins, then the smaller key, then the lower slot
	assign better = !have_best_q || (rd_entry.prio > best_q.prio) ||
		((rd_entry.prio == best_q.prio) && (rd_entry.key < best_q.key));

	assign elapsed_sum  = {1'b0, elapsed_q} + {{(ptd_pkg::CNT_W + 1 - ptd_pkg::BURST_W){1'b0}},
		best_q.burst};
	assign elapsed_nxt  = elapsed_sum[ptd_pkg::CNT_W] ? ptd_pkg::CNT_MAX :
		elapsed_sum[ptd_pkg::CNT_W-1:0];
	assign dispatch_nxt = (dispatch_q == ptd_pkg::CNT_MAX) ? dispatch_q : dispatch_q + 1'b1;

	always_comb begin
		res_push                = 1'b0;
		res_data                = '0;
		res_data.elapsed_total  = elapsed_q;
		res_data.dispatch_total = dispatch_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					res_push = (cmd.op == ptd_pkg::OP_ADD) ? table_full : table_empty;
				end
			end
			ST_ADD: begin
				res_push          = slot_free;
				res_data.accepted = 1'b1;
			end
			ST_DONE: begin
				res_push                = 1'b1;
				res_data.found          = 1'b1;
				res_data.out_key        = best_q.key;
				res_data.out_priority   = best_q.prio;
				res_data.out_burst      = best_q.burst;
				res_data.elapsed_total  = elapsed_nxt;
				res_data.dispatch_total = dispatch_nxt;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	ptd_ram #(
		.WIDTH ($bits(ptd_pkg::entry_t)),
		.DEPTH (MAX_TASKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (cmd_q.entry),
		.raddr (idx_q),
		.rdata (rd_bits)
	);

	always_ff @(posedge clk) begin
		rd_vld_s1 <= valid_q[idx_q];
		rd_idx_s1 <= idx_q;
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (rd_act_s1 && rd_vld_s1 && better) begin
			best_q     <= rd_entry;
			best_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			elapsed_q   <= '0;
			dispatch_q  <= '0;
			have_best_q <= 1'b0;
			rd_act_s1   <= 1'b0;
		end else begin
			rd_act_s1 <= (state_q == ST_SCAN);
			if (rd_act_s1 && rd_vld_s1 && better) begin
				have_best_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q       <= '0;
					have_best_q <= 1'b0;
					if (cmd_take) begin
						if (cmd.op == ptd_pkg::OP_ADD) begin
							if (!table_full) begin
								state_q <= ST_ADD;
							end
						end else if (!table_empty) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_ADD: begin
					if (slot_free) begin
						valid_q[idx_q] <= 1'b1;
						count_q        <= count_q + 1'b1;
						state_q        <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (idx_q == IW'(MAX_TASKS - 1)) begin
						idx_q   <= '0;
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					valid_q[best_idx_q] <= 1'b0;
					count_q             <= count_q - 1'b1;
					elapsed_q           <= elapsed_nxt;
					dispatch_q          <= dispatch_nxt;
					state_q             <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ptd_fifo #(
		.WIDTH ($bits(ptd_pkg::rsp_t)),
		.DEPTH (ptd_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_bits),
		.empty  (empty)
	);

	assign response = ptd_pkg::rsp_t'(res_bits);

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(valid_q))
		else $error("fill count disagrees with valid bits");

	a_done_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> have_best_q && valid_q[best_idx_q])
		else $error("dispatch finished without a valid winner");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full || (state_q != ST_IDLE))
		else $error("result pushed into full queue at command start");

	a_add_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |-> !table_full)
		else $error("slot search entered with full table");

endmodule

FILE: rtl/core/priority_task_dispatcher_unit.sv
// top level of the priority task dispatcher
// depends on ptd_pkg, ptd_front and ptd_back
//
// usage
//   request channel: queue style, an item transfers on a rising edge with push high
//   and full low. func 0 adds a task, func 1 dispatches the best pending task
//   response channel: queue style, the oldest result sits on response while empty
//   is low and transfers on a rising edge with pop high and empty low
//   every request gives exactly one response, in request order
// operation
//   add: a full table rejects the task, else it is written into the lowest free slot
//   dispatch: an empty table gives a not-found result, else the table ram is scanned
//   one entry per cycle through a single comparator
//   the back end works on one command at a time; a two-entry command queue lets
//   requests land while it is busy
// reset
//   arst_n low empties the table, both queues and clears both counters
// receiver stall
//   results wait in a two-entry result queue; once it is full the back end holds
//   the next command, the command queue fills and full goes high
module priority_task_dispatcher_unit #(
	parameter int MAX_TASKS  = ptd_pkg::MAX_TASKS_DEF,
	parameter int NAME_CHARS = ptd_pkg::NAME_CHARS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ptd_pkg::req_t request,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output ptd_pkg::rsp_t response
);

	// command path from front to back
	ptd_pkg::cmd_t  cmd;
	logic           cmd_empty;
	ptd_pkg::qctl_t cmd_ctl;

	// front: key trimming, op decode, command queue
	ptd_front #(
		.NAME_CHARS (NAME_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.request    (request),
		.full       (full),
		.cmd_ctl_in (cmd_ctl),
		.cmd        (cmd),
		.cmd_empty  (cmd_empty)
	);

	// back: task table, scan, counters, result queue
	ptd_back #(
		.MAX_TASKS (MAX_TASKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_ctl   (cmd_ctl),
		.pop       (pop),
		.empty     (empty),
		.response  (response)
	);

endmodule

FILE: verif/tb_priority_task_dispatcher_unit.sv
// self-checking testbench for priority_task_dispatcher_unit: directed and random add and
// dispatch transfers, each response checked against a scheduler predictor kept in the bench
// depends on ptd_pkg and the priority_task_dispatcher_unit rtl
module tb_priority_task_dispatcher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TASK_SLOTS = ptd_pkg::MAX_TASKS_DEF;
	localparam int KEY_CHARS  = ptd_pkg::NAME_CHARS_DEF;
	localparam int KW = ptd_pkg::KEY_W;
	localparam int PW = ptd_pkg::PRIO_W;
	localparam int BW = ptd_pkg::BURST_W;
	localparam int NW = ptd_pkg::CNT_W;
	// bytes past the name length are cleared on entry
	localparam logic [KW-1:0] KEY_KEEP = {KW{1'b1}} << ((8 - KEY_CHARS) * 8);
	localparam int RANDOM_ITEMS = 750;
	// final drain wait, long enough to cover several dispatch scans
	localparam int DRAIN_CYCLES = 4 * (TASK_SLOTS + 4);
	// watchdog limit for ~770 items plus long sender gaps and receiver stalls
	localparam int CYCLE_LIMIT = 400000;
	localparam int KEY_POOL_N = 6;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           push = 1'b0;
	logic           pop = 1'b0;
	ptd_pkg::req_t  request = '0;
	logic           full;
	logic           empty;
	ptd_pkg::rsp_t  response;

	priority_task_dispatcher_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.request  (request),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.response (response)
	);

	// requests waiting to be pushed, and responses we still expect, oldest first
	ptd_pkg::req_t task_req_q[$];
	ptd_pkg::rsp_t outcome_q[$];

	// shadow of the task table and the two saturating counters
	logic          slot_busy [TASK_SLOTS];
	logic [KW-1:0] slot_key  [TASK_SLOTS];
	logic [PW-1:0] slot_prio [TASK_SLOTS];
	logic [BW-1:0] slot_burst[TASK_SLOTS];
	int unsigned   run_ticks = 0;
	int unsigned   run_dispatches = 0;

	logic [KW-1:0] key_pool[KEY_POOL_N];
	int            send_idle_pct = 12;
	int            recv_idle_pct = 82;
	int            fail_count = 0;
	int unsigned   cycle_count = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// applies one request to the shadow table and returns the response it must produce
	function automatic ptd_pkg::rsp_t schedule_item(ptd_pkg::req_t r);
		ptd_pkg::rsp_t o;
		logic [KW-1:0] k;
		int            best;
		int            i;
		o = '0;
		k = r.task_key & KEY_KEEP;
		best = -1;
		if (r.func == ptd_pkg::OP_ADD) begin
			// lowest free slot takes the task; a full table drops it
			for (i = 0; i < TASK_SLOTS; i++) begin
				if (!slot_busy[i] && !o.accepted) begin
					slot_busy[i]  = 1'b1;
					slot_key[i]   = k;
					slot_prio[i]  = r.task_priority;
					slot_burst[i] = r.task_burst;
					o.accepted    = 1'b1;
				end
			end
		end else begin
			// highest priority, then smaller key; full tie keeps the lower slot
			for (i = 0; i < TASK_SLOTS; i++) begin
				if (slot_busy[i] && (best < 0 || slot_prio[i] > slot_prio[best] ||
						(slot_prio[i] == slot_prio[best] && slot_key[i] < slot_key[best])))
					best = i;
			end
			if (best >= 0) begin
				o.found        = 1'b1;
				o.out_key      = slot_key[best];
				o.out_priority = slot_prio[best];
				o.out_burst    = slot_burst[best];
				slot_busy[best] = 1'b0;
				run_ticks = run_ticks + 32'(slot_burst[best]);
				if (run_ticks > 32'(ptd_pkg::CNT_MAX))
					run_ticks = 32'(ptd_pkg::CNT_MAX);
				if (run_dispatches < 32'(ptd_pkg::CNT_MAX))
					run_dispatches++;
			end
		end
		o.elapsed_total  = run_ticks[NW-1:0];
		o.dispatch_total = run_dispatches[NW-1:0];
		return o;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// one response transfer against the oldest expectation
	task automatic check_outcome(ptd_pkg::rsp_t got);
		ptd_pkg::rsp_t want;
		if (outcome_q.size() == 0) begin
			$display("%0t ns: response with nothing expected, expected none, actual %h",
				$time, got);
			fail_count++;
		end else begin
			want = outcome_q.pop_front();
			compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
			compare_field("found", 64'(want.found), 64'(got.found));
			compare_field("out_key", want.out_key, got.out_key);
			compare_field("out_priority", 64'(want.out_priority), 64'(got.out_priority));
			compare_field("out_burst", 64'(want.out_burst), 64'(got.out_burst));
			compare_field("elapsed_total", 64'(want.elapsed_total), 64'(got.elapsed_total));
			compare_field("dispatch_total", 64'(want.dispatch_total),
				64'(got.dispatch_total));
		end
	endtask

	// driver: everything changes on the falling edge, idling at the phase's rates
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop  <= 1'b0;
		end else begin
			if (task_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push    <= 1'b1;
				request <= task_req_q[0];
			end else begin
				push <= 1'b0;
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: sample both transfers on the rising edge; the response is checked
	// before a request of the same edge is predicted, since it belongs to an older one
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_outcome(response);
			if (push && !full) begin
				outcome_q.push_back(schedule_item(request));
				void'(task_req_q.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("priority_task_dispatcher_unit verification failed");
			$finish;
		end
	end

	function automatic ptd_pkg::req_t make_req(ptd_pkg::op_t op, logic [KW-1:0] k,
			logic [PW-1:0] p, logic [BW-1:0] b);
		ptd_pkg::req_t r;
		r.func          = op;
		r.task_key      = k;
		r.task_priority = p;
		r.task_burst    = b;
		return r;
	endfunction

	// mix of raw 64-bit keys, NUL padded names and a small pool that forces key ties
	function automatic logic [KW-1:0] pick_key();
		logic [KW-1:0] k;
		int            len;
		int            c;
		k = '0;
		case ($urandom_range(9))
			0, 1, 2, 3: k = {$urandom, $urandom};
			4, 5, 6: begin
				len = $urandom_range(1, KEY_CHARS);
				for (c = 0; c < 8; c++)
					k = {k[KW-9:0], (c < len) ? 8'($urandom_range(1, 255)) : 8'h00};
			end
			default: k = key_pool[$urandom_range(KEY_POOL_N - 1)];
		endcase
		return k;
	endfunction

	function automatic logic [BW-1:0] pick_burst();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return BW'($urandom_range((1 << BW) - 1));
		endcase
	endfunction

	// extremes of every field, both ops, dispatch on an empty table, key and full ties
	task automatic queue_directed();
		task_req_q.push_back(make_req(ptd_pkg::OP_DISPATCH, '0, '0, '0));
		task_req_q.push_back(make_req(ptd_pkg::OP_ADD, '1, 4'hF, '1));
		task_req_q.push_back(make_req(ptd_pkg::OP_ADD, '0, 4'h0, '0));
		task_req_q.push_back(make_req(ptd_pkg::OP_ADD, {"b", 56'h0}, 4'h5, 10'd10));
		task_req_q.push_back(make_req(ptd_pkg::OP_ADD, {"a", 56'h0}, 4'h5, 10'd20));
		// same name and priority again: the earlier slot has to go first
		task_req_q.push_back(make_req(ptd_pkg::OP_ADD, {"a", 56'h0}, 4'h5, 10'd30));
		task_req_q.push_back(make_req(ptd_pkg::OP_ADD, {8'h80, 56'h0}, 4'hF, 10'd1));
		task_req_q.push_back(make_req(ptd_pkg::OP_ADD, {"m", 56'h0}, 4'hA, 10'h2AA));
		task_req_q.push_back(make_req(ptd_pkg::OP_ADD, 64'h5555_5555_5555_5555, 4'h5,
			10'h155));
		repeat (9)
			task_req_q.push_back(make_req(ptd_pkg::OP_DISPATCH, '1, '1, '1));
	endtask

	// segments lean toward adds (table fills, drops), dispatches (table drains) or mix both evenly
	task automatic queue_random(int n);
		int            left;
		int            seg;
		int            add_pct;
		ptd_pkg::req_t r;
		left = n;
		while (left > 0) begin
			seg = $urandom_range(5, 40);
			case ($urandom_range(2))
				0: add_pct = 20;
				1: add_pct = 50;
				default: add_pct = 85;
			endcase
			while (seg > 0 && left > 0) begin
				r.func          = ($urandom_range(99) < add_pct) ? ptd_pkg::OP_ADD :
					ptd_pkg::OP_DISPATCH;
				r.task_key      = pick_key();
				r.task_priority = PW'($urandom_range((1 << PW) - 1));
				r.task_burst    = pick_burst();
				task_req_q.push_back(r);
				seg--;
				left--;
			end
		end
	endtask

	task automatic wait_all_sent();
		while (task_req_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < TASK_SLOTS; i++)
			slot_busy[i] = 1'b0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = {"ab", 48'h0};
		key_pool[3] = {"abc", 40'h0};
		key_pool[4] = {"abd", 40'h0};
		key_pool[5] = {$urandom, $urandom};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// slow receiver
		queue_directed();
		queue_random(RANDOM_ITEMS / 3);
		wait_all_sent();

		// slow sender
		send_idle_pct = 82;
		recv_idle_pct = 12;
		queue_random(RANDOM_ITEMS / 3);
		wait_all_sent();

		// full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		wait_all_sent();

		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("priority_task_dispatcher_unit verification clean");
		end else begin
			$display("priority_task_dispatcher_unit verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/ptd_pkg.sv
rtl/core/ptd_ram.sv
rtl/core/ptd_fifo.sv
rtl/core/ptd_front.sv
rtl/core/ptd_back.sv
rtl/core/priority_task_dispatcher_unit.sv
verif/tb_priority_task_dispatcher_unit.sv
